// ===== rtl/eo3s_pkg.sv =====
// shared widths, types and constants for the exact orient3d sign pipeline
package eo3s_pkg;

	// width of every coordinate port
	localparam int FIELD_W = 32;
	// low bits of each port that hold the coordinate, sign-extended from there
	localparam int COORD_BITS = 32;

	localparam int CW = COORD_BITS;
	// product of two coordinates
	localparam int PW = 2 * CW;
	// difference of two products (2d cross)
	localparam int KW = PW + 1;
	// coordinate times one half of a cross value
	localparam int PPW = 2 * CW + 1;
	// column sum of three partial products
	localparam int SW = PPW + 2;
	// full determinant
	localparam int DW = SW + CW + 1;

	// number of tie-break tests in the chain
	localparam int NUM_TB = 12;

	typedef logic signed [CW-1:0] coord_t;
	typedef logic signed [PW-1:0] prod_t;
	typedef logic signed [KW-1:0] cross_t;
	typedef logic signed [PPW-1:0] part_t;
	typedef logic signed [SW-1:0] colsum_t;
	typedef logic signed [DW-1:0] det_t;

	// one tie-break test: it decides when nz is set, and then gives ans
	typedef struct packed {
		logic nz;
		logic ans;
	} tb_test_t;

	typedef tb_test_t [NUM_TB-1:0] tb_chain_t;

endpackage

// ===== rtl/eo3s_tiebreak.sv =====
// priority chain that picks the first deciding tie-break test
module eo3s_tiebreak (
	input  eo3s_pkg::tb_chain_t tests,
	output logic                result
);
	import eo3s_pkg::*;

	// scan from the last test so the first deciding test wins
	always_comb begin
		result = 1'b1;
		for (int i = NUM_TB - 1; i >= 0; i--) begin
			if (tests[i].nz) begin
				result = tests[i].ans;
			end
		end
	end

endmodule

// ===== rtl/exact_orient3d_sos_sign_top.sv =====
// five-stage pipeline for the exact orient3d sign with simplicity tie-breaking
// the result reaches the stage 5 output register after passing each earlier stage register in turn
// throughput: one item per cycle while out_stall is low, with no gap between transfers
// a stage holds only while it and every later stage are full and out_stall is high
// the depth is set by the 32x33 partial products of a . (b x c) and their wide sums
// reset clears only the stage valid bits; payload registers are not reset
module exact_orient3d_sos_sign_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic signed [eo3s_pkg::FIELD_W-1:0] a_x,
	input  logic signed [eo3s_pkg::FIELD_W-1:0] a_y,
	input  logic signed [eo3s_pkg::FIELD_W-1:0] a_z,
	input  logic signed [eo3s_pkg::FIELD_W-1:0] b_x,
	input  logic signed [eo3s_pkg::FIELD_W-1:0] b_y,
	input  logic signed [eo3s_pkg::FIELD_W-1:0] b_z,
	input  logic signed [eo3s_pkg::FIELD_W-1:0] c_x,
	input  logic signed [eo3s_pkg::FIELD_W-1:0] c_y,
	input  logic signed [eo3s_pkg::FIELD_W-1:0] c_z,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic                                is_positive
);
	import eo3s_pkg::*;

	// stage control
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic en_s1, en_s2, en_s3, en_s4, en_s5;

	assign en_s5 = !v_s5 || !out_stall;
	assign en_s4 = !v_s4 || en_s5;
	assign en_s3 = !v_s3 || en_s4;
	assign en_s2 = !v_s2 || en_s3;
	assign en_s1 = !v_s1 || en_s2;
	assign in_stall = !en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= in_valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
			if (en_s5) v_s5 <= v_s4;
		end
	end

	// stage 1: coordinate products
	coord_t ax, ay, az, bx, by, bz, cx, cy, cz;
	assign ax = a_x[CW-1:0];
	assign ay = a_y[CW-1:0];
	assign az = a_z[CW-1:0];
	assign bx = b_x[CW-1:0];
	assign by = b_y[CW-1:0];
	assign bz = b_z[CW-1:0];
	assign cx = c_x[CW-1:0];
	assign cy = c_y[CW-1:0];
	assign cz = c_z[CW-1:0];

	prod_t p_bycz_s1, p_bzcy_s1, p_bzcx_s1, p_bxcz_s1, p_bxcy_s1, p_bycx_s1;
	prod_t p_axcy_s1, p_aycx_s1, p_axcz_s1, p_azcx_s1, p_axby_s1, p_aybx_s1;
	coord_t ax_s1, ay_s1, az_s1, bx_s1, by_s1, cx_s1, cy_s1, cz_s1;

	always_ff @(posedge clk) begin
		if (en_s1) begin
			p_bycz_s1 <= by * cz;
			p_bzcy_s1 <= bz * cy;
			p_bzcx_s1 <= bz * cx;
			p_bxcz_s1 <= bx * cz;
			p_bxcy_s1 <= bx * cy;
			p_bycx_s1 <= by * cx;
			p_axcy_s1 <= ax * cy;
			p_aycx_s1 <= ay * cx;
			p_axcz_s1 <= ax * cz;
			p_azcx_s1 <= az * cx;
			p_axby_s1 <= ax * by;
			p_aybx_s1 <= ay * bx;
			ax_s1 <= ax;
			ay_s1 <= ay;
			az_s1 <= az;
			bx_s1 <= bx;
			by_s1 <= by;
			cx_s1 <= cx;
			cy_s1 <= cy;
			cz_s1 <= cz;
		end
	end

	// stage 2: cross products of b and c, tie-break decision
	cross_t kx, ky, kz, x_ac_xy, x_ac_xz, x_ab_xy;
	assign kx      = KW'(p_bycz_s1) - KW'(p_bzcy_s1);
	assign ky      = KW'(p_bzcx_s1) - KW'(p_bxcz_s1);
	assign kz      = KW'(p_bxcy_s1) - KW'(p_bycx_s1);
	assign x_ac_xy = KW'(p_axcy_s1) - KW'(p_aycx_s1);
	assign x_ac_xz = KW'(p_axcz_s1) - KW'(p_azcx_s1);
	assign x_ab_xy = KW'(p_axby_s1) - KW'(p_aybx_s1);

	tb_chain_t tb_tests;
	logic      tb_result;

	// cross(b.xz, c.xz) is -ky, so its "negative" test is ky positive
	always_comb begin
		tb_tests[0]  = '{nz: |kz,      ans: !kz[KW-1]};
		tb_tests[1]  = '{nz: |ky,      ans: !ky[KW-1]};
		tb_tests[2]  = '{nz: |kx,      ans: !kx[KW-1]};
		tb_tests[3]  = '{nz: |x_ac_xy, ans: x_ac_xy[KW-1]};
		tb_tests[4]  = '{nz: |cx_s1,   ans: !cx_s1[CW-1]};
		tb_tests[5]  = '{nz: |cy_s1,   ans: cy_s1[CW-1]};
		tb_tests[6]  = '{nz: |x_ac_xz, ans: !x_ac_xz[KW-1]};
		tb_tests[7]  = '{nz: |cz_s1,   ans: !cz_s1[CW-1]};
		tb_tests[8]  = '{nz: |x_ab_xy, ans: !x_ab_xy[KW-1]};
		tb_tests[9]  = '{nz: |bx_s1,   ans: bx_s1[CW-1]};
		tb_tests[10] = '{nz: |by_s1,   ans: !by_s1[CW-1]};
		tb_tests[11] = '{nz: |ax_s1,   ans: !ax_s1[CW-1]};
	end

	eo3s_tiebreak u_tiebreak (
		.tests  (tb_tests),
		.result (tb_result)
	);

	cross_t kx_s2, ky_s2, kz_s2;
	coord_t ax_s2, ay_s2, az_s2;
	logic   tb_s2;

	always_ff @(posedge clk) begin
		if (en_s2) begin
			kx_s2 <= kx;
			ky_s2 <= ky;
			kz_s2 <= kz;
			ax_s2 <= ax_s1;
			ay_s2 <= ay_s1;
			az_s2 <= az_s1;
			tb_s2 <= tb_result;
		end
	end

	// stage 3: partial products of a times the split cross values
	logic signed [CW:0] kx_hi, ky_hi, kz_hi, kx_lo, ky_lo, kz_lo;
	assign kx_hi = $signed(kx_s2[KW-1:CW]);
	assign ky_hi = $signed(ky_s2[KW-1:CW]);
	assign kz_hi = $signed(kz_s2[KW-1:CW]);
	assign kx_lo = $signed({1'b0, kx_s2[CW-1:0]});
	assign ky_lo = $signed({1'b0, ky_s2[CW-1:0]});
	assign kz_lo = $signed({1'b0, kz_s2[CW-1:0]});

	part_t ph_x_s3, ph_y_s3, ph_z_s3, pl_x_s3, pl_y_s3, pl_z_s3;
	logic  tb_s3;

	always_ff @(posedge clk) begin
		if (en_s3) begin
			ph_x_s3 <= ax_s2 * kx_hi;
			ph_y_s3 <= ay_s2 * ky_hi;
			ph_z_s3 <= az_s2 * kz_hi;
			pl_x_s3 <= ax_s2 * kx_lo;
			pl_y_s3 <= ay_s2 * ky_lo;
			pl_z_s3 <= az_s2 * kz_lo;
			tb_s3   <= tb_s2;
		end
	end

	// stage 4: column sums of high and low halves
	colsum_t sum_hi_s4, sum_lo_s4;
	logic    tb_s4;

	always_ff @(posedge clk) begin
		if (en_s4) begin
			sum_hi_s4 <= SW'(ph_x_s3) + SW'(ph_y_s3) + SW'(ph_z_s3);
			sum_lo_s4 <= SW'(pl_x_s3) + SW'(pl_y_s3) + SW'(pl_z_s3);
			tb_s4     <= tb_s3;
		end
	end

	// stage 5: recombine the determinant and pick the sign
	det_t det;
	logic pos_next;
	assign det      = (DW'(sum_hi_s4) <<< CW) + DW'(sum_lo_s4);
	assign pos_next = (|det) ? !det[DW-1] : tb_s4;

	logic pos_s5;

	always_ff @(posedge clk) begin
		if (en_s5) begin
			pos_s5 <= pos_next;
		end
	end

	assign out_valid   = v_s5;
	assign is_positive = pos_s5;

endmodule
